// File: src/multidim_histogram_accumulator_core_macros.svh
// Assertion helpers shared by the histogram core.
`ifndef MULTIDIM_HISTOGRAM_ACCUMULATOR_CORE_MACROS_SVH
`define MULTIDIM_HISTOGRAM_ACCUMULATOR_CORE_MACROS_SVH

// Checked on every rising clock edge, off while reset is active.
`define MHA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("histogram core assertion failed");

// Checked on every rising clock edge, reset included.
`define MHA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("histogram core assertion failed");

`endif

// File: src/mha_pkg.sv
`default_nettype none

package mha_pkg;

  // Default sizes
  localparam int MAX_BINS_PER_DIM = 64;
  localparam int COORD_BITS       = 16;
  localparam int COUNT_BITS       = 32;

  // Fixed field widths
  localparam int BINS_W   = 7;
  localparam int WEIGHT_W = 16;
  localparam int INDEX_W  = 12;
  localparam int VALUE_W  = 32;
  localparam int REG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_DIM0_MIN  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIM0_MAX  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIM0_BINS = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIM1_MIN  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIM1_MAX  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DIM1_BINS = 3'd5;

  localparam logic [BINS_W-1:0] BINS_RESET = 7'd64;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_BELOW = 2'd1;
  localparam logic [1:0] STAT_ABOVE = 2'd2;

  typedef enum logic [1:0] {
    KIND_ACC   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_ACC    = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_REPORT = 2'd3
  } op_e;

  // Control part of a command between front and back
  typedef struct packed {
    op_e        op;
    logic [1:0] status;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_CHECK = 4'b0010,
    F_DIV   = 4'b0100,
    F_PUSH  = 4'b1000
  } front_state_e;

  typedef enum logic [3:0] {
    B_INIT  = 4'b0001,
    B_IDLE  = 4'b0010,
    B_WB    = 4'b0100,
    B_SWEEP = 4'b1000
  } back_state_e;

endpackage

`default_nettype wire

// File: src/mha_front.sv
`default_nettype none

module mha_front #(
  parameter int MaxBins   = mha_pkg::MAX_BINS_PER_DIM,
  parameter int CoordBits = mha_pkg::COORD_BITS,
  parameter int CfgW      = (CoordBits > mha_pkg::BINS_W) ? CoordBits : mha_pkg::BINS_W,
  parameter int FlatW     = 2 * $clog2(MaxBins)
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // configuration
  input  wire                               cfg_we_i,
  input  wire [mha_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  wire [CfgW-1:0]                    cfg_data_i,
  // item request
  input  wire                               push_i,
  output logic                              busy_o,
  input  wire [1:0]                         kind_i,
  input  wire signed [CoordBits-1:0]        coord0_i,
  input  wire signed [CoordBits-1:0]        coord1_i,
  input  wire signed [mha_pkg::WEIGHT_W-1:0] weight_i,
  // command out
  output logic                              cmd_push_o,
  input  wire                               cmd_full_i,
  output mha_pkg::cmd_t                     cmd_o,
  output logic [FlatW-1:0]                  cmd_flat_o,
  output logic [mha_pkg::WEIGHT_W-1:0]      cmd_weight_o
);

  localparam int BB    = $clog2(MaxBins);
  localparam int EbW   = $clog2(MaxBins + 1);
  localparam int NumW  = CoordBits + BB;
  localparam int CntW  = $clog2(BB) + 1;
  localparam logic [CntW-1:0] LastStep = CntW'(BB - 1);
  localparam logic signed [CoordBits-1:0] MinReset = {1'b1, {(CoordBits-1){1'b0}}};
  localparam logic signed [CoordBits-1:0] MaxReset = {1'b0, {(CoordBits-1){1'b1}}};

  // Configuration registers
  logic signed [CoordBits-1:0]     min0_q, max0_q, min1_q, max1_q;
  logic [mha_pkg::BINS_W-1:0]      bins0_q, bins1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min0_q  <= MinReset;
      max0_q  <= MaxReset;
      bins0_q <= mha_pkg::BINS_RESET;
      min1_q  <= MinReset;
      max1_q  <= MaxReset;
      bins1_q <= mha_pkg::BINS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mha_pkg::REG_DIM0_MIN:  min0_q  <= CoordBits'(cfg_data_i);
        mha_pkg::REG_DIM0_MAX:  max0_q  <= CoordBits'(cfg_data_i);
        mha_pkg::REG_DIM0_BINS: bins0_q <= mha_pkg::BINS_W'(cfg_data_i);
        mha_pkg::REG_DIM1_MIN:  min1_q  <= CoordBits'(cfg_data_i);
        mha_pkg::REG_DIM1_MAX:  max1_q  <= CoordBits'(cfg_data_i);
        mha_pkg::REG_DIM1_BINS: bins1_q <= mha_pkg::BINS_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Bin count in use: zero means one, capped at the table size
  function automatic logic [EbW-1:0] eff_bins(input logic [mha_pkg::BINS_W-1:0] b);
    logic [EbW-1:0] r;
    if (b == '0) r = EbW'(1);
    else if (int'(b) > MaxBins) r = EbW'(MaxBins);
    else r = EbW'(b);
    return r;
  endfunction

  mha_pkg::front_state_e state_q, state_d;
  logic [1:0]                  kind_q;
  logic signed [CoordBits-1:0] c0_q, c1_q;
  logic [mha_pkg::WEIGHT_W-1:0] w_q;
  logic                        dim_q;
  logic [BB-1:0]               row_q;
  logic [1:0]                  status_q;
  logic [CoordBits-1:0]        rem_q, den_q;
  logic [BB-1:0]               low_q;
  logic [CntW-1:0]             cnt_q;

  // Current dimension operands
  logic signed [CoordBits-1:0] x, lo, hi;
  logic [EbW-1:0]              eb, eb1;
  logic signed [CoordBits:0]   dx, rx;
  logic [NumW:0]               prod;
  logic [NumW-1:0]             num;
  logic [CoordBits:0]          trial;
  logic                        ge;
  logic [CoordBits-1:0]        rem_next;
  logic [BB-1:0]               low_next;

  always_comb begin
    x   = dim_q ? c1_q : c0_q;
    lo  = dim_q ? min1_q : min0_q;
    hi  = dim_q ? max1_q : max0_q;
    eb  = eff_bins(dim_q ? bins1_q : bins0_q);
    eb1 = eff_bins(bins1_q);
    dx  = (CoordBits+1)'(x) - (CoordBits+1)'(lo);
    rx  = (CoordBits+1)'(hi) - (CoordBits+1)'(lo);
    // dividend (d+1)*b-1, below r*b
    prod = (NumW+1)'((CoordBits+1)'(dx[CoordBits-1:0]) + (CoordBits+1)'(1))
         * (NumW+1)'(eb);
    num  = NumW'(prod - (NumW+1)'(1));
    // one restoring division step
    trial    = {rem_q, low_q[BB-1]};
    ge       = trial >= {1'b0, den_q};
    rem_next = ge ? CoordBits'(trial - {1'b0, den_q}) : trial[CoordBits-1:0];
    low_next = BB'({low_q, ge});
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      mha_pkg::F_IDLE: begin
        if (push_i) begin
          if (kind_i == mha_pkg::KIND_ACC || kind_i == mha_pkg::KIND_QUERY)
            state_d = mha_pkg::F_CHECK;
          else
            state_d = mha_pkg::F_PUSH;
        end
      end
      mha_pkg::F_CHECK: begin
        if (x < lo || x >= hi) state_d = mha_pkg::F_PUSH;
        else state_d = mha_pkg::F_DIV;
      end
      mha_pkg::F_DIV: begin
        if (cnt_q == LastStep) state_d = dim_q ? mha_pkg::F_PUSH : mha_pkg::F_CHECK;
      end
      mha_pkg::F_PUSH: begin
        if (!cmd_full_i) state_d = mha_pkg::F_IDLE;
      end
      default: state_d = mha_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mha_pkg::F_IDLE;
      dim_q    <= 1'b0;
      status_q <= mha_pkg::STAT_OK;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        mha_pkg::F_IDLE: begin
          dim_q    <= 1'b0;
          status_q <= mha_pkg::STAT_OK;
        end
        mha_pkg::F_CHECK: begin
          cnt_q <= '0;
          if (x < lo) status_q <= mha_pkg::STAT_BELOW;
          else if (x >= hi) status_q <= mha_pkg::STAT_ABOVE;
        end
        mha_pkg::F_DIV: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == LastStep) dim_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Item and divider datapath
  always_ff @(posedge clk_i) begin
    if (state_q == mha_pkg::F_IDLE && push_i) begin
      kind_q <= kind_i;
      c0_q   <= coord0_i;
      c1_q   <= coord1_i;
      w_q    <= weight_i;
    end
    if (state_q == mha_pkg::F_CHECK) begin
      rem_q <= num[NumW-1:BB];
      low_q <= num[BB-1:0];
      den_q <= rx[CoordBits-1:0];
    end
    if (state_q == mha_pkg::F_DIV) begin
      rem_q <= rem_next;
      low_q <= low_next;
      if (cnt_q == LastStep && !dim_q) row_q <= low_next;
    end
  end

  // Command out
  always_comb begin
    cmd_o.status = status_q;
    if (status_q != mha_pkg::STAT_OK) cmd_o.op = mha_pkg::OP_REPORT;
    else begin
      case (kind_q)
        mha_pkg::KIND_ACC:   cmd_o.op = mha_pkg::OP_ACC;
        mha_pkg::KIND_QUERY: cmd_o.op = mha_pkg::OP_READ;
        mha_pkg::KIND_CLEAR: cmd_o.op = mha_pkg::OP_CLEAR;
        default:             cmd_o.op = mha_pkg::OP_REPORT;
      endcase
    end
    cmd_flat_o   = FlatW'(FlatW'(row_q) * FlatW'(eb1) + FlatW'(low_q));
    cmd_weight_o = w_q;
    cmd_push_o   = (state_q == mha_pkg::F_PUSH) && !cmd_full_i;
    busy_o       = (state_q != mha_pkg::F_IDLE);
  end

endmodule

`default_nettype wire

// File: src/mha_cmd_fifo.sv
`default_nettype none

module mha_cmd_fifo #(
  parameter int Width = 8
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire [Width-1:0]  data_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  // Two-entry queue
  logic [Width-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i) count_q <= count_q + 2'd1;
      else if (pop_i && !push_i) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= data_i;
  end

  assign data_o  = slot_q[rd_ptr_q];
  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);

endmodule

`default_nettype wire

// File: src/mha_back.sv
`default_nettype none

module mha_back #(
  parameter int MaxBins   = mha_pkg::MAX_BINS_PER_DIM,
  parameter int CountBits = mha_pkg::COUNT_BITS,
  parameter int FlatW     = 2 * $clog2(MaxBins)
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // command in
  input  wire                                cmd_empty_i,
  output logic                               cmd_pop_o,
  input  wire mha_pkg::cmd_t                 cmd_i,
  input  wire [FlatW-1:0]                    cmd_flat_i,
  input  wire signed [mha_pkg::WEIGHT_W-1:0] cmd_weight_i,
  output logic                               init_o,
  // result queue side
  output logic                               empty,
  input  wire                                pop,
  output logic [1:0]                         status_o,
  output logic [mha_pkg::INDEX_W-1:0]        bin_index_o,
  output logic signed [mha_pkg::VALUE_W-1:0] bin_value_o
);

  localparam int Depth = MaxBins * MaxBins;
  localparam logic [FlatW-1:0] LastAddr = FlatW'(Depth - 1);

  mha_pkg::back_state_e state_q, state_d;
  mha_pkg::cmd_t        cmd_q;
  logic [FlatW-1:0]     flat_q, sweep_q;
  logic signed [mha_pkg::WEIGHT_W-1:0] w_q;

  // Counter memory, registered read
  logic signed [CountBits-1:0] mem [Depth];
  logic signed [CountBits-1:0] rd_q;
  logic                        mem_we;
  logic [FlatW-1:0]            mem_waddr;
  logic signed [CountBits-1:0] mem_wdata;

  logic                        out_free, wb_go;
  logic signed [CountBits:0]   sum;
  logic signed [CountBits-1:0] sat;

  logic                          out_valid_q;
  logic [1:0]                    status_q;
  logic [mha_pkg::INDEX_W-1:0]   index_q;
  logic signed [mha_pkg::VALUE_W-1:0] value_q;

  assign out_free  = !out_valid_q || pop;
  assign wb_go     = (state_q == mha_pkg::B_WB) && out_free;
  assign cmd_pop_o = (state_q == mha_pkg::B_IDLE) && !cmd_empty_i;

  // Saturating add
  always_comb begin
    sum = (CountBits+1)'(rd_q) + (CountBits+1)'(w_q);
    if (sum[CountBits] != sum[CountBits-1])
      sat = sum[CountBits] ? {1'b1, {(CountBits-1){1'b0}}} : {1'b0, {(CountBits-1){1'b1}}};
    else
      sat = sum[CountBits-1:0];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = flat_q;
    mem_wdata = sat;
    if (state_q == mha_pkg::B_INIT || state_q == mha_pkg::B_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_q;
      mem_wdata = '0;
    end else if (wb_go && cmd_q.op == mha_pkg::OP_ACC) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) rd_q <= mem[cmd_flat_i];
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      mha_pkg::B_INIT:  if (sweep_q == LastAddr) state_d = mha_pkg::B_IDLE;
      mha_pkg::B_IDLE: begin
        if (!cmd_empty_i)
          state_d = (cmd_i.op == mha_pkg::OP_CLEAR) ? mha_pkg::B_SWEEP : mha_pkg::B_WB;
      end
      mha_pkg::B_SWEEP: if (sweep_q == LastAddr) state_d = mha_pkg::B_WB;
      mha_pkg::B_WB:    if (out_free) state_d = mha_pkg::B_IDLE;
      default:          state_d = mha_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mha_pkg::B_INIT;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == mha_pkg::B_INIT || state_q == mha_pkg::B_SWEEP)
        sweep_q <= (sweep_q == LastAddr) ? '0 : sweep_q + FlatW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q  <= cmd_i;
      flat_q <= cmd_flat_i;
      w_q    <= cmd_weight_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (wb_go) out_valid_q <= 1'b1;
    else if (pop) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (wb_go) begin
      status_q <= cmd_q.status;
      case (cmd_q.op)
        mha_pkg::OP_ACC: begin
          index_q <= mha_pkg::INDEX_W'(flat_q);
          value_q <= mha_pkg::VALUE_W'(sat);
        end
        mha_pkg::OP_READ: begin
          index_q <= mha_pkg::INDEX_W'(flat_q);
          value_q <= mha_pkg::VALUE_W'(rd_q);
        end
        default: begin
          index_q <= '0;
          value_q <= '0;
        end
      endcase
    end
  end

  assign empty       = !out_valid_q;
  assign status_o    = status_q;
  assign bin_index_o = index_q;
  assign bin_value_o = value_q;
  assign init_o      = (state_q == mha_pkg::B_INIT);

endmodule

`default_nettype wire

// File: src/multidim_histogram_accumulator_core.sv
// Two-dimensional uniform histogram with saturating signed counters. Items enter through a
// queue-like port (push/full) and each gives one result on the output queue (empty/pop).
// The front locates both coordinates with one shared restoring divider, one quotient bit per
// cycle: an accumulate or query keeps the front busy through a check and a division for
// each coordinate and a push to the command queue, which waits while that queue is full;
// an out-of-range coordinate skips any further division. The back reads the counter when
// it takes a command and writes it back later, on its single-port memory. A clear item
// sweeps all MaxBins^2 counters, one per cycle, before its result appears. After reset the
// same sweep runs once and full stays high until it ends; configuration writes are taken throughout.
`default_nettype none

`include "multidim_histogram_accumulator_core_macros.svh"

module multidim_histogram_accumulator_core #(
  parameter int MaxBins   = mha_pkg::MAX_BINS_PER_DIM,
  parameter int CoordBits = mha_pkg::COORD_BITS,
  parameter int CountBits = mha_pkg::COUNT_BITS,
  parameter int CfgW      = (CoordBits > mha_pkg::BINS_W) ? CoordBits : mha_pkg::BINS_W
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // configuration
  input  wire                                cfg_we_i,
  input  wire [mha_pkg::REG_IDX_W-1:0]       cfg_idx_i,
  input  wire [CfgW-1:0]                     cfg_data_i,
  // item request
  input  wire                                push,
  output logic                               full,
  input  wire [1:0]                          kind_i,
  input  wire signed [CoordBits-1:0]         coord0_i,
  input  wire signed [CoordBits-1:0]         coord1_i,
  input  wire signed [mha_pkg::WEIGHT_W-1:0] weight_i,
  // result
  output logic                               empty,
  input  wire                                pop,
  output logic [1:0]                         status_o,
  output logic [mha_pkg::INDEX_W-1:0]        bin_index_o,
  output logic signed [mha_pkg::VALUE_W-1:0] bin_value_o
);

  localparam int FlatW = 2 * $clog2(MaxBins);
  localparam int QW    = mha_pkg::CMD_W + FlatW + mha_pkg::WEIGHT_W;

  logic                         front_busy, back_init;
  logic                         cmd_push, cmd_full, cmd_pop, cmd_empty;
  mha_pkg::cmd_t                f_cmd, b_cmd;
  logic [FlatW-1:0]             f_flat, b_flat;
  logic [mha_pkg::WEIGHT_W-1:0] f_weight, b_weight;
  logic [QW-1:0]                q_in, q_out;

  assign full = front_busy || back_init;

  mha_front #(
    .MaxBins   (MaxBins),
    .CoordBits (CoordBits),
    .CfgW      (CfgW),
    .FlatW     (FlatW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push && !full),
    .busy_o       (front_busy),
    .kind_i       (kind_i),
    .coord0_i     (coord0_i),
    .coord1_i     (coord1_i),
    .weight_i     (weight_i),
    .cmd_push_o   (cmd_push),
    .cmd_full_i   (cmd_full),
    .cmd_o        (f_cmd),
    .cmd_flat_o   (f_flat),
    .cmd_weight_o (f_weight)
  );

  // Command queue between front and back
  assign q_in = {f_cmd, f_flat, f_weight};
  assign {b_cmd, b_flat, b_weight} = q_out;

  mha_cmd_fifo #(
    .Width (QW)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (q_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (q_out),
    .empty_o (cmd_empty)
  );

  mha_back #(
    .MaxBins   (MaxBins),
    .CountBits (CountBits),
    .FlatW     (FlatW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_empty_i  (cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .cmd_i        (b_cmd),
    .cmd_flat_i   (b_flat),
    .cmd_weight_i (b_weight),
    .init_o       (back_init),
    .empty        (empty),
    .pop          (pop),
    .status_o     (status_o),
    .bin_index_o  (bin_index_o),
    .bin_value_o  (bin_value_o)
  );

  // Queue between front and back never overflows or underflows
  `MHA_ASSERT(a_cmd_no_overflow, cmd_push |-> !cmd_full)
  `MHA_ASSERT(a_cmd_no_underflow, cmd_pop |-> !cmd_empty)
  // An accepted item keeps the front busy on the next cycle
  `MHA_ASSERT(a_front_takes_item, (push && !full) |=> front_busy)
  // No item is taken while the counters are being initialized
  `MHA_ASSERT_ALWAYS(a_no_accept_in_init, back_init |-> full)

endmodule

`default_nettype wire
